### src/clipped_convolution_matrix_indexer_unit_macros.svh
// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_CONVOLUTION_MATRIX_INDEXER_UNIT_MACROS_SVH
`define CLIPPED_CONVOLUTION_MATRIX_INDEXER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define CCMI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CCMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CCMI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CCMI_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/ccmi_pkg.sv
// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer package
// Shared widths, payload types, register indexes and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ccmi_pkg;

  localparam int MAX_IMAGE_SIDE  = 256;
  localparam int MAX_KERNEL_SIDE = 8;

  localparam int IMG_SIDE_W = 9;
  localparam int KER_SIDE_W = 4;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 2'd3;

  localparam logic [IMG_SIDE_W-1:0] IMAGE_ROWS_RST  = 9'd64;
  localparam logic [IMG_SIDE_W-1:0] IMAGE_COLS_RST  = 9'd64;
  localparam logic [KER_SIDE_W-1:0] KERNEL_ROWS_RST = 4'd3;
  localparam logic [KER_SIDE_W-1:0] KERNEL_COLS_RST = 4'd3;

  localparam logic [IMG_SIDE_W-1:0] IMAGE_SIDE_CAP  = IMG_SIDE_W'(MAX_IMAGE_SIDE);
  localparam logic [KER_SIDE_W-1:0] KERNEL_SIDE_CAP = KER_SIDE_W'(MAX_KERNEL_SIDE);

  typedef struct packed {
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
  } pixel_t;

  typedef struct packed {
    logic [15:0] matrix_row;
    logic [15:0] matrix_col;
    logic [5:0]  kernel_index;
    logic        last;
  } entry_t;

  // Image and kernel sides after clamping to their maximums.
  typedef struct packed {
    logic [IMG_SIDE_W-1:0] image_rows;
    logic [IMG_SIDE_W-1:0] image_cols;
    logic [KER_SIDE_W-1:0] kernel_rows;
    logic [KER_SIDE_W-1:0] kernel_cols;
  } cfg_t;

  typedef struct packed {
    logic load_pixel;
    logic calc_span;
    logic calc_base;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic slot_free;
    logic last_beat;
  } dp_sts_t;

endpackage

`default_nettype wire

### src/clipped_convolution_matrix_indexer_unit.sv
// An accepted pixel passes the span and base setup states, then the walk counters
// give W beats, W = clipped window rows x columns (1 to 64), to the output register,
// one beat per cycle while the output does not stall; no new pixel is taken until
// the walk ends. A pixel outside the image or a zero side yields no beats.
// Reset (rst, synchronous): sides return to 64 x 64 image and 3 x 3 kernel,
// the controller goes idle and the output register is emptied.
`default_nettype none

// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer
// Emits the sparse blurring-matrix entries of one output pixel per request.
// ----------------------------------------------------------------------------
module clipped_convolution_matrix_indexer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ccmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ccmi_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ccmi_pkg::pixel_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ccmi_pkg::entry_t                      out_data
);

  ccmi_pkg::cfg_t     cfg;
  ccmi_pkg::ctl_cmd_t cmd;
  ccmi_pkg::dp_sts_t  sts;

  ccmi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ccmi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccmi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/ccmi_cfg.sv
// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer configuration registers
// Holds the image and kernel sides and presents them clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module ccmi_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [ccmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ccmi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ccmi_pkg::cfg_t                        cfg
);

  logic [ccmi_pkg::IMG_SIDE_W-1:0] image_rows;
  logic [ccmi_pkg::IMG_SIDE_W-1:0] image_cols;
  logic [ccmi_pkg::KER_SIDE_W-1:0] kernel_rows;
  logic [ccmi_pkg::KER_SIDE_W-1:0] kernel_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_rows  <= ccmi_pkg::IMAGE_ROWS_RST;
      image_cols  <= ccmi_pkg::IMAGE_COLS_RST;
      kernel_rows <= ccmi_pkg::KERNEL_ROWS_RST;
      kernel_cols <= ccmi_pkg::KERNEL_COLS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ccmi_pkg::REG_IMAGE_ROWS:  image_rows  <= cfg_data;
        ccmi_pkg::REG_IMAGE_COLS:  image_cols  <= cfg_data;
        ccmi_pkg::REG_KERNEL_ROWS: kernel_rows <= cfg_data[ccmi_pkg::KER_SIDE_W-1:0];
        ccmi_pkg::REG_KERNEL_COLS: kernel_cols <= cfg_data[ccmi_pkg::KER_SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.image_rows  = (image_rows > ccmi_pkg::IMAGE_SIDE_CAP) ?
                      ccmi_pkg::IMAGE_SIDE_CAP : image_rows;
    cfg.image_cols  = (image_cols > ccmi_pkg::IMAGE_SIDE_CAP) ?
                      ccmi_pkg::IMAGE_SIDE_CAP : image_cols;
    cfg.kernel_rows = (kernel_rows > ccmi_pkg::KERNEL_SIDE_CAP) ?
                      ccmi_pkg::KERNEL_SIDE_CAP : kernel_rows;
    cfg.kernel_cols = (kernel_cols > ccmi_pkg::KERNEL_SIDE_CAP) ?
                      ccmi_pkg::KERNEL_SIDE_CAP : kernel_cols;
  end

endmodule

`default_nettype wire

### src/ccmi_ctrl.sv
// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer controller
// Sequences pixel capture, window setup and the per-entry walk.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clipped_convolution_matrix_indexer_unit_macros.svh"

module ccmi_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ccmi_pkg::dp_sts_t sts,
  output ccmi_pkg::ctl_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SPAN = 2'd1;
  localparam logic [1:0] ST_BASE = 2'd2;
  localparam logic [1:0] ST_RUN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = ST_SPAN;
        end
      end
      ST_SPAN: begin
        // A pixel outside the image, or a zero side, yields no entries.
        cmd.calc_span = 1'b1;
        state_next    = sts.empty ? ST_IDLE : ST_BASE;
      end
      ST_BASE: begin
        cmd.calc_base = 1'b1;
        state_next    = ST_RUN;
      end
      ST_RUN: begin
        if (sts.slot_free) begin
          cmd.step = 1'b1;
          if (sts.last_beat) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CCMI_ASSERT_NEXT(a_accept, clk, rst, in_valid && !in_stall, state == ST_SPAN, "no setup")
  `CCMI_ASSERT_NEXT(a_empty, clk, rst, state == ST_SPAN && sts.empty, !in_stall, "empty held")
  `CCMI_ASSERT_NEXT(a_last, clk, rst, cmd.step && sts.last_beat, !in_stall, "walk overran")

endmodule

`default_nettype wire

### src/ccmi_datapath.sv
// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer datapath
// Window clipping, base index products, walk counters and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "clipped_convolution_matrix_indexer_unit_macros.svh"

module ccmi_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ccmi_pkg::cfg_t     cfg,
  input  wire ccmi_pkg::pixel_t   in_data,
  input  wire ccmi_pkg::ctl_cmd_t cmd,
  output ccmi_pkg::dp_sts_t       sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ccmi_pkg::entry_t        out_data
);

  typedef struct packed {
    logic [3:0] pre;
    logic [3:0] off;
    logic [3:0] len;
  } span_t;

  // Clipped window along one axis: pre is the reach before the pixel, off the
  // kernel offset of the first tap, len the number of taps kept.
  function automatic span_t axis_span(input logic [7:0] k, input logic [3:0] n,
                                      input logic [8:0] m);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] pre;
    logic [3:0] post;
    logic [8:0] rem;
    span_t      s;
    a    = n >> 1;
    b    = n - a;
    pre  = ({4'b0, a} > k) ? k[3:0] : a;
    rem  = m - {1'b0, k};
    post = (rem < {5'b0, b}) ? rem[3:0] : b;
    s.pre = pre;
    s.off = a - pre;
    s.len = pre + post;
    return s;
  endfunction

  logic [7:0]  pix_row;
  logic [7:0]  pix_col;
  span_t       span_y;
  span_t       span_x;
  logic [15:0] row_index;
  logic [15:0] row_base;
  logic [7:0]  src_col0;
  logic [5:0]  kbase;
  logic [2:0]  row_cnt;
  logic [2:0]  col_cnt;

  span_t       span_y_next;
  span_t       span_x_next;
  logic [16:0] row_prod;
  logic [7:0]  src_row0;
  logic [16:0] base_prod;
  logic [7:0]  kprod;
  logic [3:0]  row_cnt_w;
  logic [3:0]  col_cnt_w;
  logic        row_end;
  logic        col_end;

  assign span_y_next = axis_span(pix_row, cfg.kernel_rows, cfg.image_rows);
  assign span_x_next = axis_span(pix_col, cfg.kernel_cols, cfg.image_cols);
  assign row_prod    = {9'b0, pix_row} * {8'b0, cfg.image_cols};
  assign src_row0    = pix_row - {4'b0, span_y.pre};
  assign base_prod   = {9'b0, src_row0} * {8'b0, cfg.image_cols};
  assign kprod       = {4'b0, span_y.off} * {4'b0, cfg.kernel_cols};

  assign row_cnt_w = {1'b0, row_cnt};
  assign col_cnt_w = {1'b0, col_cnt};
  assign row_end   = (row_cnt_w == span_y.len - 4'd1);
  assign col_end   = (col_cnt_w == span_x.len - 4'd1);

  always_comb begin
    sts.empty = (cfg.image_rows == '0) || (cfg.image_cols == '0) ||
                (cfg.kernel_rows == '0) || (cfg.kernel_cols == '0) ||
                ({1'b0, pix_row} >= cfg.image_rows) ||
                ({1'b0, pix_col} >= cfg.image_cols);
    sts.slot_free = !out_valid || !out_stall;
    sts.last_beat = row_end && col_end;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      pix_row <= in_data.pixel_row;
      pix_col <= in_data.pixel_col;
    end
    if (cmd.calc_span) begin
      span_y    <= span_y_next;
      span_x    <= span_x_next;
      row_index <= row_prod[15:0] + {8'b0, pix_col};
    end
    if (cmd.calc_base) begin
      row_base <= base_prod[15:0];
      src_col0 <= pix_col - {4'b0, span_x.pre};
      kbase    <= kprod[5:0] + {2'b0, span_x.off};
      row_cnt  <= '0;
      col_cnt  <= '0;
    end else if (cmd.step) begin
      if (col_end) begin
        col_cnt  <= '0;
        row_cnt  <= row_cnt + 3'd1;
        row_base <= row_base + {7'b0, cfg.image_cols};
        kbase    <= kbase + {2'b0, cfg.kernel_cols};
      end else begin
        col_cnt <= col_cnt + 3'd1;
      end
    end
  end

  // Output register: a finished beat waits here while the walk holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_data.matrix_row   <= row_index;
      out_data.matrix_col   <= row_base + {8'b0, src_col0} + {13'b0, col_cnt};
      out_data.kernel_index <= kbase + {3'b0, col_cnt};
      out_data.last         <= row_end && col_end;
    end
  end

  `CCMI_ASSERT_IMPLY(a_row_in_win, clk, rst, cmd.step, row_cnt_w < span_y.len, "row overran")
  `CCMI_ASSERT_IMPLY(a_col_in_win, clk, rst, cmd.step, col_cnt_w < span_x.len, "col overran")

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// Clipped convolution matrix indexer testbench
// Drives output pixels through the valid/stall input channel and checks every
// emitted matrix entry against a clipped kernel window worked out in the bench.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    int pre;
    int post;
    int off;
  } axis_span_t;

  typedef logic [ccmi_pkg::CFG_DATA_W-1:0] cfg_word_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [ccmi_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ccmi_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  ccmi_pkg::pixel_t                in_data;
  logic                            out_valid;
  logic                            out_stall;
  ccmi_pkg::entry_t                out_data;

  // Bench copy of the side registers, as written (before clamping).
  logic [ccmi_pkg::IMG_SIDE_W-1:0] img_rows;
  logic [ccmi_pkg::IMG_SIDE_W-1:0] img_cols;
  logic [ccmi_pkg::KER_SIDE_W-1:0] ker_rows;
  logic [ccmi_pkg::KER_SIDE_W-1:0] ker_cols;

  ccmi_pkg::entry_t expected_entries[$];
  int               fail_count;
  bit               idle_on;
  bit               stall_on;

  clipped_convolution_matrix_indexer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= stall_on && ($urandom_range(0, 99) < 19);
  end

  function automatic int clamp_side(int v, int cap);
    return (v > cap) ? cap : v;
  endfunction

  // Window span along one axis for position k, kernel side n, image side m.
  function automatic axis_span_t clip_axis(int k, int n, int m);
    axis_span_t s;
    int q;
    if (n % 2 == 0) begin
      q = n / 2;
      if (k < q) begin
        s.pre = k; s.post = q; s.off = q - k;
      end else if (k > m - q - 1) begin
        s.pre = q; s.post = m - k; s.off = 0;
      end else begin
        s.pre = q; s.post = q; s.off = 0;
      end
    end else begin
      q = (n + 1) / 2;
      if (k < q - 1) begin
        s.pre = k; s.post = q; s.off = q - 1 - k;
      end else if (k > m - q - 1) begin
        s.pre = q - 1; s.post = m - k; s.off = 0;
      end else begin
        s.pre = q - 1; s.post = q; s.off = 0;
      end
    end
    // A kernel wider than the image must still stop at the last pixel.
    if (s.post > m - k) s.post = m - k;
    return s;
  endfunction

  task automatic predict_entries(input ccmi_pkg::pixel_t px);
    int mr, mc, kr, kc, pr, pc, rows, cols, total, n;
    axis_span_t ys, xs;
    ccmi_pkg::entry_t e;
    mr = clamp_side(int'(img_rows), ccmi_pkg::MAX_IMAGE_SIDE);
    mc = clamp_side(int'(img_cols), ccmi_pkg::MAX_IMAGE_SIDE);
    kr = clamp_side(int'(ker_rows), ccmi_pkg::MAX_KERNEL_SIDE);
    kc = clamp_side(int'(ker_cols), ccmi_pkg::MAX_KERNEL_SIDE);
    pr = int'(px.pixel_row);
    pc = int'(px.pixel_col);
    if (mr == 0 || mc == 0 || kr == 0 || kc == 0) return;
    if (pr >= mr || pc >= mc) return;
    ys = clip_axis(pr, kr, mr);
    xs = clip_axis(pc, kc, mc);
    rows = ys.pre + ys.post;
    cols = xs.pre + xs.post;
    if (rows <= 0 || cols <= 0) return;
    total = rows * cols;
    n = 0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        e.matrix_row   = 16'(pr * mc + pc);
        e.matrix_col   = 16'((pr - ys.pre + r) * mc + (pc - xs.pre + c));
        e.kernel_index = 6'((ys.off + r) * kc + (xs.off + c));
        e.last         = (n == total - 1);
        expected_entries.insert(expected_entries.size(), e);
        n++;
      end
    end
  endtask

  task automatic check_entry(input ccmi_pkg::entry_t got);
    ccmi_pkg::entry_t want;
    if (expected_entries.size() == 0) begin
      $error("unexpected entry: matrix_row %0d matrix_col %0d kernel_index %0d last %0d",
             got.matrix_row, got.matrix_col, got.kernel_index, got.last);
      fail_count++;
      return;
    end
    want = expected_entries.pop_front();
    if (got.matrix_row !== want.matrix_row) begin
      $error("matrix_row: expected %0d, actual %0d", want.matrix_row, got.matrix_row);
      fail_count++;
    end
    if (got.matrix_col !== want.matrix_col) begin
      $error("matrix_col: expected %0d, actual %0d", want.matrix_col, got.matrix_col);
      fail_count++;
    end
    if (got.kernel_index !== want.kernel_index) begin
      $error("kernel_index: expected %0d, actual %0d", want.kernel_index, got.kernel_index);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, actual %0d", want.last, got.last);
      fail_count++;
    end
  endtask

  // Handshake signals only change at the rising edge, so the values seen at the
  // falling edge are the ones the next rising edge samples.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) check_entry(out_data);
  end

  task automatic write_side(input logic [ccmi_pkg::CFG_IDX_W-1:0] idx,
                            input logic [ccmi_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      ccmi_pkg::REG_IMAGE_ROWS: begin
        img_rows = value[ccmi_pkg::IMG_SIDE_W-1:0];
      end
      ccmi_pkg::REG_IMAGE_COLS: begin
        img_cols = value[ccmi_pkg::IMG_SIDE_W-1:0];
      end
      ccmi_pkg::REG_KERNEL_ROWS: begin
        ker_rows = value[ccmi_pkg::KER_SIDE_W-1:0];
      end
      ccmi_pkg::REG_KERNEL_COLS: begin
        ker_cols = value[ccmi_pkg::KER_SIDE_W-1:0];
      end
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_sides(input int ir, input int ic, input int kr, input int kc);
    write_side(ccmi_pkg::REG_IMAGE_ROWS, cfg_word_t'(ir));
    write_side(ccmi_pkg::REG_IMAGE_COLS, cfg_word_t'(ic));
    write_side(ccmi_pkg::REG_KERNEL_ROWS, cfg_word_t'(kr));
    write_side(ccmi_pkg::REG_KERNEL_COLS, cfg_word_t'(kc));
  endtask

  // Called at a rising edge; returns at the rising edge that takes the beat.
  // Valid stays high afterwards so back-to-back pixels need no extra step.
  task automatic send_pixel(input int row, input int col);
    ccmi_pkg::pixel_t px;
    logic stalled;
    px.pixel_row = 8'(row);
    px.pixel_col = 8'(col);
    while (idle_on && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    predict_entries(px);
  endtask

  // Pixels with no entries still pass through the span state, so
  // allow a short settle after the last entry before touching the registers.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_sides();
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(0, 63);
    send_pixel(32, 17);
    drain();
  endtask

  task automatic test_outside_image();
    send_pixel(64, 0);
    send_pixel(0, 64);
    send_pixel(255, 255);
    send_pixel(63, 0);
    drain();
  endtask

  task automatic test_even_kernel();
    set_sides(16, 10, 4, 2);
    send_pixel(0, 0);
    send_pixel(1, 1);
    send_pixel(15, 9);
    send_pixel(8, 5);
    send_pixel(14, 8);
    drain();
  endtask

  task automatic test_oversized_sides();
    // Image sides above the cap clamp to 256; kernel writes keep the low
    // nibble, and 15 clamps to 8.
    set_sides(511, 256, 9'h1FF, 9'h1F8);
    send_pixel(255, 255);
    send_pixel(0, 0);
    send_pixel(128, 77);
    drain();
  endtask

  task automatic test_kernel_over_image();
    set_sides(1, 3, 8, 5);
    send_pixel(0, 0);
    send_pixel(0, 2);
    send_pixel(0, 1);
    drain();
    set_sides(2, 1, 7, 8);
    send_pixel(1, 0);
    drain();
  endtask

  task automatic test_zero_sides();
    set_sides(0, 4, 3, 3);
    send_pixel(0, 0);
    drain();
    set_sides(4, 4, 1, 0);
    send_pixel(2, 2);
    drain();
    write_side(ccmi_pkg::REG_KERNEL_COLS, cfg_word_t'(1));
    send_pixel(3, 1);
    drain();
  endtask

  function automatic logic [ccmi_pkg::CFG_DATA_W-1:0] random_image_side();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return cfg_word_t'($urandom_range(257, 511));
    if (pick == 1) return cfg_word_t'(1);
    if (pick == 2) return cfg_word_t'(256);
    if (pick < 6) return cfg_word_t'($urandom_range(2, 16));
    return cfg_word_t'($urandom_range(17, 255));
  endfunction

  function automatic logic [ccmi_pkg::CFG_DATA_W-1:0] random_kernel_side();
    int k;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(1, 8);
    // Upper bits are not stored by the kernel registers but still get toggled.
    return {5'($urandom), 4'(k)};
  endfunction

  function automatic int random_coord(input int side);
    int pick, offset;
    pick = $urandom_range(0, 99);
    if (side == 0 || pick < 15) return $urandom_range(0, 255);
    if (pick < 35) begin
      offset = $urandom_range(0, 2);
      if (offset >= side) offset = side - 1;
      return $urandom_range(0, 1) ? offset : side - 1 - offset;
    end
    return $urandom_range(0, side - 1);
  endfunction

  task automatic test_random_pixels();
    int mr, mc;
    for (int phase = 0; phase < 8; phase++) begin
      write_side(ccmi_pkg::REG_IMAGE_ROWS, random_image_side());
      write_side(ccmi_pkg::REG_IMAGE_COLS, random_image_side());
      write_side(ccmi_pkg::REG_KERNEL_ROWS, random_kernel_side());
      write_side(ccmi_pkg::REG_KERNEL_COLS, random_kernel_side());
      // One phase runs with neither side ever pausing.
      idle_on  = (phase != 3);
      stall_on = (phase != 3);
      mr = clamp_side(int'(img_rows), ccmi_pkg::MAX_IMAGE_SIDE);
      mc = clamp_side(int'(img_cols), ccmi_pkg::MAX_IMAGE_SIDE);
      for (int i = 0; i < 12; i++) begin
        send_pixel(random_coord(mr), random_coord(mc));
      end
      drain();
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = ccmi_pkg::REG_IMAGE_ROWS;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    fail_count = 0;
    idle_on    = 1'b1;
    stall_on   = 1'b1;
    img_rows   = ccmi_pkg::IMAGE_ROWS_RST;
    img_cols   = ccmi_pkg::IMAGE_COLS_RST;
    ker_rows   = ccmi_pkg::KERNEL_ROWS_RST;
    ker_cols   = ccmi_pkg::KERNEL_COLS_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_sides();
    test_outside_image();
    test_even_kernel();
    test_oversized_sides();
    test_kernel_over_image();
    test_zero_sides();
    test_random_pixels();

    if (fail_count == 0 && expected_entries.size() == 0) begin
      $display("clipped_convolution_matrix_indexer_unit verification clean");
    end else begin
      $display("clipped_convolution_matrix_indexer_unit verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("clipped_convolution_matrix_indexer_unit verification failed");
    $finish;
  end

endmodule
